// ----- design/pcc_pkg.sv -----
package pcc_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BASE  = 2'd1;
    localparam logic [1:0] OP_DEL   = 2'd2;
    localparam logic [1:0] OP_CALL  = 2'd3;

    // counter slots within one position
    localparam int         NUM_SLOTS  = 6;
    localparam logic [2:0] SLOT_N     = 3'd4;
    localparam logic [2:0] SLOT_DEL   = 3'd5;

    // configuration register indexes
    localparam logic REG_AF_THRESHOLD = 1'b0;
    localparam logic REG_MIN_DEPTH    = 1'b1;

    localparam int CFG_WIDTH = 16;
    localparam int AF_WIDTH  = 9;

    localparam logic [AF_WIDTH-1:0]  AF_THRESHOLD_RST = 9'd205;
    localparam logic [CFG_WIDTH-1:0] MIN_DEPTH_RST    = 16'd10;

    typedef struct packed {
        logic [1:0]  operation;
        logic [13:0] position;
        logic [2:0]  base_code;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  called_base;
        logic [15:0] top_count;
        logic        af_filtered;
        logic        depth_filtered;
        logic        called;
        logic        range_error;
    } t_out_item;

endpackage

// ----- design/pileup_consensus_caller_top.sv -----
// channel   | ports                              | transfer
// ----------+------------------------------------+--------------------------------
// item in   | start, busy, i_item                | edge with start high, busy low
// result    | o_valid, o_result                  | every cycle o_valid is high
// config    | i_cfg_we, i_cfg_idx, i_cfg_data    | every edge with i_cfg_we high
//
// a start item needs no further state, a base or deletion item goes through a memory read, then
// increment and write back, and a call goes through read, max and sum, then af multiply;
// any item out of range is answered from the idle state
// a result shows in the cycle after the item's last cycle, for one cycle
// after reset busy stays high while the whole count
// memory is cleared one row per cycle; config writes are taken meanwhile
// the receiver cannot stall, so nothing waits on the result side
module pileup_consensus_caller_top #(
    parameter int NUM_POSITIONS = 16384,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  pcc_pkg::t_in_item                  i_item,
    output logic                               o_valid,
    output pcc_pkg::t_out_item                 o_result,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [pcc_pkg::CFG_WIDTH-1:0]      i_cfg_data
);

    localparam int AW = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
    localparam int WW = $clog2(NUM_POSITIONS + 1);
    localparam int DW = pcc_pkg::NUM_SLOTS * COUNT_WIDTH;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BASE  = 2'd1;
    localparam logic [1:0] ST_CALL1 = 2'd2;
    localparam logic [1:0] ST_CALL2 = 2'd3;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic                           r_clr_active;
    logic [AW-1:0]                  r_clr_addr;
    logic [WW-1:0]                  r_walk;
    logic [WW-1:0]                  n_walk;
    logic [AW-1:0]                  r_addr;
    logic [AW-1:0]                  n_addr;
    logic [2:0]                     r_slot;
    logic [2:0]                     n_slot;
    logic [pcc_pkg::AF_WIDTH-1:0]   r_af_threshold;
    logic [pcc_pkg::CFG_WIDTH-1:0]  r_min_depth;
    logic                           r_out_valid;
    logic                           n_out_valid;
    pcc_pkg::t_out_item             r_out;
    pcc_pkg::t_out_item             n_out;
    pcc_pkg::t_out_item             eval_result;

    logic                           accept;
    logic                           pos_oor;
    logic                           walk_oor;
    logic [AW-1:0]                  rd_addr;
    logic [DW-1:0]                  rd_data;
    logic                           mem_we;
    logic [AW-1:0]                  wr_addr;
    logic [DW-1:0]                  wr_data;
    pcc_pkg::t_out_item             err_item;

    assign busy     = r_clr_active || (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign pos_oor  = 32'(i_item.position) >= 32'(NUM_POSITIONS);
    assign walk_oor = 32'(r_walk) >= 32'(NUM_POSITIONS);
    assign rd_addr  = (i_item.operation == pcc_pkg::OP_CALL) ? AW'(i_item.position)
                                                              : r_walk[AW-1:0];

    always_comb begin
        err_item             = '0;
        err_item.range_error = 1'b1;
    end

    // control sequencer
    always_comb begin
        n_state     = r_state;
        n_walk      = r_walk;
        n_addr      = r_addr;
        n_slot      = r_slot;
        n_out_valid = 1'b0;
        n_out       = r_out;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_item.operation)
                        pcc_pkg::OP_START: begin
                            if (pos_oor) begin
                                n_out_valid = 1'b1;
                                n_out       = err_item;
                            end else begin
                                n_walk = WW'(i_item.position);
                            end
                        end
                        pcc_pkg::OP_BASE, pcc_pkg::OP_DEL: begin
                            if (walk_oor) begin
                                n_out_valid = 1'b1;
                                n_out       = err_item;
                            end else begin
                                n_addr  = r_walk[AW-1:0];
                                n_walk  = r_walk + 1'b1;
                                n_state = ST_BASE;
                                if (i_item.operation == pcc_pkg::OP_DEL) begin
                                    n_slot = pcc_pkg::SLOT_DEL;
                                end else if (i_item.base_code > pcc_pkg::SLOT_N) begin
                                    n_slot = pcc_pkg::SLOT_N;
                                end else begin
                                    n_slot = i_item.base_code;
                                end
                            end
                        end
                        default: begin
                            if (pos_oor) begin
                                n_out_valid = 1'b1;
                                n_out       = err_item;
                            end else begin
                                n_state = ST_CALL1;
                            end
                        end
                    endcase
                end
            end
            ST_BASE: begin
                n_state = ST_IDLE;
            end
            ST_CALL1: begin
                n_state = ST_CALL2;
            end
            ST_CALL2: begin
                n_out_valid = 1'b1;
                n_out       = eval_result;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // write port: clearing sweep, or saturating bump of one slot
    always_comb begin
        mem_we  = r_clr_active || (r_state == ST_BASE);
        wr_addr = r_clr_active ? r_clr_addr : r_addr;
        wr_data = rd_data;
        for (int s = 0; s < pcc_pkg::NUM_SLOTS; s++) begin
            if ((3'(s) == r_slot) && (rd_data[s*COUNT_WIDTH +: COUNT_WIDTH] != '1)) begin
                wr_data[s*COUNT_WIDTH +: COUNT_WIDTH] =
                    rd_data[s*COUNT_WIDTH +: COUNT_WIDTH] + 1'b1;
            end
        end
        if (r_clr_active) begin
            wr_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_clr_active   <= 1'b1;
            r_clr_addr     <= '0;
            r_walk         <= '0;
            r_out_valid    <= 1'b0;
            r_af_threshold <= pcc_pkg::AF_THRESHOLD_RST;
            r_min_depth    <= pcc_pkg::MIN_DEPTH_RST;
        end else begin
            r_state     <= n_state;
            r_walk      <= n_walk;
            r_out_valid <= n_out_valid;
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(NUM_POSITIONS - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pcc_pkg::REG_AF_THRESHOLD: r_af_threshold <= i_cfg_data[pcc_pkg::AF_WIDTH-1:0];
                    pcc_pkg::REG_MIN_DEPTH:    r_min_depth    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_slot <= n_slot;
        r_out  <= n_out;
    end

    pcc_count_mem #(
        .DEPTH (NUM_POSITIONS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pcc_eval #(
        .CW (COUNT_WIDTH)
    ) u_eval (
        .i_clk          (i_clk),
        .i_load         (r_state == ST_CALL1),
        .i_row          (rd_data),
        .i_af_threshold (r_af_threshold),
        .i_min_depth    (r_min_depth),
        .o_result       (eval_result)
    );

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // no result can appear while the memory is being cleared
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !o_valid)
        else $error("result during clearing sweep");

    // an in-range call delivers its result after ST_CALL1, ST_CALL2 and the result register
    a_call_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.operation == pcc_pkg::OP_CALL) && !pos_oor) |-> ##3 o_valid)
        else $error("call result missing");

    // an in-range start item gives no result
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.operation == pcc_pkg::OP_START) && !pos_oor) |=> !o_valid)
        else $error("start item produced a result");

    // a call never writes the count memory
    a_call_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CALL1) || (r_state == ST_CALL2)) |-> !mem_we)
        else $error("memory write during call");

endmodule

// ----- design/pcc_count_mem.sv -----
module pcc_count_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 96
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/pcc_eval.sv -----
module pcc_eval #(
    parameter int CW = 16
) (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic [pcc_pkg::NUM_SLOTS*CW-1:0]  i_row,
    input  logic [pcc_pkg::AF_WIDTH-1:0]      i_af_threshold,
    input  logic [pcc_pkg::CFG_WIDTH-1:0]     i_min_depth,
    output pcc_pkg::t_out_item                o_result
);

    localparam int SW = CW + 3;
    localparam int PW = SW + pcc_pkg::AF_WIDTH;

    logic [1:0]    n_best;
    logic [CW-1:0] n_top;
    logic [SW-1:0] n_sum;
    logic [1:0]    r_best;
    logic [CW-1:0] r_top;
    logic [SW-1:0] r_sum;
    logic [PW-1:0] prod;
    logic [PW-1:0] top_scaled;
    logic          aff;
    logic          dpf;

    // first stage: first maximum among the four bases and the total depth
    always_comb begin
        n_best = 2'd0;
        n_top  = i_row[CW-1:0];
        n_sum  = '0;
        for (int i = 1; i < 4; i++) begin
            if (i_row[i*CW +: CW] > n_top) begin
                n_best = 2'(i);
                n_top  = i_row[i*CW +: CW];
            end
        end
        for (int i = 0; i < pcc_pkg::NUM_SLOTS; i++) begin
            n_sum = n_sum + SW'(i_row[i*CW +: CW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_best <= n_best;
            r_top  <= n_top;
            r_sum  <= n_sum;
        end
    end

    // second stage: fraction and depth filters
    always_comb begin
        prod       = PW'(r_sum) * PW'(i_af_threshold);
        top_scaled = PW'(r_top) << 8;
        aff        = top_scaled < prod;
        dpf        = 32'(r_top) < 32'(i_min_depth);
        o_result.called_base    = r_best;
        o_result.top_count      = 16'(r_top);
        o_result.af_filtered    = aff;
        o_result.depth_filtered = dpf;
        o_result.called         = !(aff || dpf);
        o_result.range_error    = 1'b0;
    end

endmodule

// ----- bench/tb_pileup_consensus_caller_top.sv -----
`timescale 1ns / 100ps

module tb_pileup_consensus_caller_top;
    import pcc_pkg::*;

    localparam int NUM_POSITIONS = 16384;
    localparam int WINDOW        = 32;
    localparam int DEEP_POS      = 20;
    localparam int CYCLE_LIMIT   = 400_000;

    localparam int BASE_A = 0;
    localparam int BASE_C = 1;
    localparam int BASE_G = 2;
    localparam int BASE_T = 3;
    localparam int BASE_N = 4;

    class pileup_scoreboard;
        bit [15:0] counts [NUM_POSITIONS][NUM_SLOTS];
        bit [14:0] walk_pos;
        bit [8:0]  af_threshold = AF_THRESHOLD_RST;
        bit [15:0] min_depth    = MIN_DEPTH_RST;
        t_out_item expected_results [$];
        int        mismatches;

        function void write_reg(logic idx, logic [15:0] data);
            if (idx == REG_AF_THRESHOLD) begin
                af_threshold = data[8:0];
            end else begin
                min_depth = data;
            end
        endfunction

        function void queue_expected(t_out_item res);
            expected_results = {expected_results, res};
        endfunction

        function void note_item(t_in_item it);
            t_out_item       res;
            bit [2:0]        slot;
            int              best;
            bit [15:0]       top;
            longint unsigned total;
            res = '0;
            res.range_error = 1'b1;
            case (it.operation)
                OP_START: begin
                    if (it.position >= NUM_POSITIONS) begin
                        queue_expected(res);
                    end else begin
                        walk_pos = it.position;
                    end
                end
                OP_BASE, OP_DEL: begin
                    if (walk_pos >= NUM_POSITIONS) begin
                        queue_expected(res);
                    end else begin
                        // codes above N count as N
                        if (it.operation == OP_DEL) begin
                            slot = SLOT_DEL;
                        end else if (it.base_code <= SLOT_N) begin
                            slot = it.base_code;
                        end else begin
                            slot = SLOT_N;
                        end
                        if (counts[walk_pos][slot] != 16'hFFFF) begin
                            counts[walk_pos][slot]++;
                        end
                        walk_pos++;
                    end
                end
                OP_CALL: begin
                    if (it.position >= NUM_POSITIONS) begin
                        queue_expected(res);
                    end else begin
                        best = 0;
                        for (int i = 1; i < 4; i++) begin
                            if (counts[it.position][i] > counts[it.position][best]) begin
                                best = i;
                            end
                        end
                        top = counts[it.position][best];
                        total = 0;
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            total += counts[it.position][i];
                        end
                        res = '0;
                        res.called_base    = best[1:0];
                        res.top_count      = top;
                        res.af_filtered    = (longint'(top) * 256) < (total * af_threshold);
                        res.depth_filtered = top < min_depth;
                        res.called         = !(res.af_filtered || res.depth_filtered);
                        queue_expected(res);
                    end
                end
            endcase
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                $error("result with no item pending: %p", got);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            check_field("called_base", want.called_base, got.called_base);
            check_field("top_count", want.top_count, got.top_count);
            check_field("af_filtered", want.af_filtered, got.af_filtered);
            check_field("depth_filtered", want.depth_filtered, got.depth_filtered);
            check_field("called", want.called, got.called);
            check_field("range_error", want.range_error, got.range_error);
        endfunction

        function void finish_check();
            if (expected_results.size() != 0) begin
                $error("%0d results never arrived", expected_results.size());
                mismatches += expected_results.size();
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in_item              i_item;
    logic                  o_valid;
    t_out_item             o_result;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_WIDTH-1:0]  i_cfg_data;

    pileup_scoreboard sb = new();
    int items_sent;
    int burst_left;
    bit gaps_on;
    int cycles;

    pileup_consensus_caller_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("pileup_consensus_caller_top regression: fail");
            $finish;
        end
    end

    // inputs and outputs as they stood during the cycle that this edge ends
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we === 1'b1) begin
                sb.write_reg(i_cfg_idx, i_cfg_data);
            end
            if (start && busy === 1'b0) begin
                sb.note_item(i_item);
            end
            if (o_valid === 1'b1) begin
                sb.check_result(o_result);
            end
        end
    end

    // returns right after the edge that takes the transfer
    task automatic send(logic [1:0] op, int pos, int code);
        t_in_item it;
        it.operation = op;
        it.position  = pos[13:0];
        it.base_code = code[2:0];
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic issue(logic [1:0] op, int pos, int code);
        send(op, pos, code);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                idle($urandom_range(1, 8));
            end
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [8:0] af, logic [15:0] depth);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_AF_THRESHOLD;
        i_cfg_data <= {7'($urandom), af};
        @(posedge i_clk);
        i_cfg_idx  <= REG_MIN_DEPTH;
        i_cfg_data <= depth;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic run_random(int count);
        int target;
        int wp;
        int len;
        int sel;
        target = items_sent + count;
        while (items_sent < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                // one read: start then a run of bases and deletions, mostly agreeing per position
                sel = $urandom_range(0, 9);
                if (sel < 7) begin
                    wp = $urandom_range(0, WINDOW - 1);
                end else if (sel < 9) begin
                    wp = $urandom_range(NUM_POSITIONS - 24, NUM_POSITIONS - 1);
                end else begin
                    wp = $urandom_range(0, NUM_POSITIONS - 1);
                end
                issue(OP_START, wp, $urandom_range(0, 7));
                len = $urandom_range(1, 30);
                repeat (len) begin
                    if ($urandom_range(0, 9) == 0) begin
                        issue(OP_DEL, $urandom, $urandom_range(0, 7));
                    end else if ($urandom_range(0, 3) != 0) begin
                        issue(OP_BASE, $urandom, (wp * 3 + 1) % 4);
                    end else begin
                        issue(OP_BASE, $urandom, $urandom_range(0, 7));
                    end
                    wp++;
                end
            end else if (sel < 92) begin
                sel = $urandom_range(0, 9);
                if (sel < 7) begin
                    wp = $urandom_range(0, WINDOW - 1);
                end else if (sel == 7) begin
                    wp = DEEP_POS;
                end else if (sel == 8) begin
                    wp = $urandom_range(NUM_POSITIONS - 24, NUM_POSITIONS - 1);
                end else begin
                    wp = $urandom_range(0, NUM_POSITIONS - 1);
                end
                issue(OP_CALL, wp, $urandom_range(0, 7));
            end else begin
                issue(2'($urandom_range(0, 3)), $urandom, $urandom_range(0, 7));
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_AF_THRESHOLD;
        i_cfg_data <= '0;
        items_sent = 0;
        burst_left = 1;
        gaps_on    = 1'b1;
        cycles     = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty call, walk running off the end, every base code
        send(OP_CALL, 0, BASE_A);
        send(OP_START, NUM_POSITIONS - 1, 7);
        send(OP_BASE, 0, BASE_T);
        send(OP_BASE, NUM_POSITIONS - 1, BASE_A);
        send(OP_DEL, 0, BASE_A);
        send(OP_CALL, NUM_POSITIONS - 1, 5);
        send(OP_START, 5, BASE_A);
        for (int c = 0; c < 8; c++) begin
            send(OP_BASE, 0, c);
        end
        send(OP_DEL, NUM_POSITIONS - 1, BASE_A);
        send(OP_CALL, 5, BASE_A);
        send(OP_CALL, 5 + BASE_N, BASE_A);
        send(OP_CALL, 12, 7);
        send(OP_CALL, 13, BASE_A);
        send(OP_START, 0, BASE_A);

        // stack one position deep, with a few other counts beside it
        repeat (12) begin
            send(OP_START, DEEP_POS, BASE_A);
            send(OP_BASE, 0, BASE_G);
        end
        repeat (3) begin
            send(OP_START, DEEP_POS, BASE_A);
            send(OP_BASE, 0, BASE_T);
            send(OP_START, DEEP_POS, BASE_A);
            send(OP_DEL, 0, BASE_A);
        end
        send(OP_CALL, DEEP_POS, BASE_A);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph != 0) begin
                drain();
                case (ph)
                    1: write_regs(9'd0, 16'd0);
                    2: write_regs(9'd256, 16'hFFFF);
                    3: write_regs(9'd511, 16'd1);
                    4: write_regs(9'd128, 16'd5);
                    default: write_regs(9'($urandom_range(0, 256)), 16'($urandom_range(0, 40)));
                endcase
            end
            gaps_on = (ph != 2);
            run_random(120);
        end

        drain();
        sb.finish_check();
        if (sb.mismatches == 0) begin
            $display("pileup_consensus_caller_top regression: pass");
        end else begin
            $display("pileup_consensus_caller_top regression: fail");
        end
        $finish;
    end

endmodule
